// ===== src/bcrr_pkg.sv =====
// Shared types, opcodes and helpers for the branch/call/return resolver.
// Used by bcrr_resolve and the top level; depends on nothing.
`default_nettype none

package bcrr_pkg;

  // Restart vectors sit on an eight-byte stride
  localparam int unsigned RstShift = 3;

  typedef enum logic [3:0] {
    ACT_JP     = 4'd0,
    ACT_JP_CC  = 4'd1,
    ACT_JR     = 4'd2,
    ACT_JR_CC  = 4'd3,
    ACT_DJNZ   = 4'd4,
    ACT_JP_HL  = 4'd5,
    ACT_CALL   = 4'd6,
    ACT_CALL_CC = 4'd7,
    ACT_RET    = 4'd8,
    ACT_RET_CC = 4'd9,
    ACT_RETI   = 4'd10,
    ACT_RETN   = 4'd11,
    ACT_RST    = 4'd12
  } action_t;

  // Flag bit positions in the F register
  localparam int unsigned FlagS  = 7;
  localparam int unsigned FlagZ  = 6;
  localparam int unsigned FlagPv = 2;
  localparam int unsigned FlagC  = 0;

  typedef struct packed {
    logic [3:0]  action;
    logic [2:0]  y_field;
    logic [7:0]  flags;
    logic [15:0] pc_in;
    logic [15:0] sp_in;
    logic [15:0] hl_in;
    logic [7:0]  b_in;
    logic [15:0] imm_word;
    logic [7:0]  disp_byte;
    logic [15:0] pop_word;
    logic        iff2_in;
  } request_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] next_sp;
    logic [7:0]  next_b;
    logic        taken;
    logic        push_enable;
    logic [15:0] push_address;
    logic [15:0] push_word;
    logic        pop_used;
    logic        iff1_load;
    logic        iff1_value;
  } result_t;

  // Evaluate condition code: NZ Z NC C PO PE P M
  function automatic logic cond_holds(input logic [2:0] idx, input logic [7:0] flags);
    logic bit_sel;
    unique case (idx[2:1])
      2'd0: bit_sel = flags[FlagZ];
      2'd1: bit_sel = flags[FlagC];
      2'd2: bit_sel = flags[FlagPv];
      default: bit_sel = flags[FlagS];
    endcase
    return bit_sel == idx[0];
  endfunction

endpackage

`default_nettype wire

// ===== src/bcrr_resolve.sv =====
// Combinational resolution of one control-flow request.
// Depends on bcrr_pkg for the opcode enum, structs and condition decode.
`default_nettype none

module bcrr_resolve (
  input  bcrr_pkg::request_t req,
  output bcrr_pkg::result_t  res
);
  import bcrr_pkg::*;

  logic [15:0] rel_target;
  logic [15:0] sp_dec;
  logic [15:0] sp_inc;
  logic [7:0]  b_dec;
  logic        cond_main;
  logic        cond_jr;
  logic [2:0]  jr_idx;
  logic [15:0] npc;
  logic        take;
  logic        push;
  logic        pop;
  logic        iload;
  action_t     act;

  // Arithmetic shared among the operations
  assign rel_target = req.pc_in + {{8{req.disp_byte[7]}}, req.disp_byte};
  assign sp_dec     = req.sp_in - 16'd2;
  assign sp_inc     = req.sp_in + 16'd2;
  assign b_dec      = req.b_in - 8'd1;
  assign jr_idx     = req.y_field - 3'd4;
  assign cond_main  = cond_holds(req.y_field, req.flags);
  assign cond_jr    = cond_holds(jr_idx, req.flags);
  assign act        = action_t'(req.action);

  // Decode the operation
  always_comb begin
    npc   = req.pc_in;
    take  = 1'b0;
    push  = 1'b0;
    pop   = 1'b0;
    iload = 1'b0;
    unique case (act)
      ACT_JP: begin
        take = 1'b1;
        npc  = req.imm_word;
      end
      ACT_JP_CC: begin
        take = cond_main;
        if (cond_main) npc = req.imm_word;
      end
      ACT_JR: begin
        take = 1'b1;
        npc  = rel_target;
      end
      ACT_JR_CC: begin
        take = cond_jr;
        if (cond_jr) npc = rel_target;
      end
      ACT_DJNZ: begin
        take = (b_dec != 8'd0);
        if (b_dec != 8'd0) npc = rel_target;
      end
      ACT_JP_HL: begin
        take = 1'b1;
        npc  = req.hl_in;
      end
      ACT_CALL: begin
        take = 1'b1;
        push = 1'b1;
        npc  = req.imm_word;
      end
      ACT_CALL_CC: begin
        take = cond_main;
        push = cond_main;
        if (cond_main) npc = req.imm_word;
      end
      ACT_RET, ACT_RETI: begin
        take = 1'b1;
        pop  = 1'b1;
      end
      ACT_RET_CC: begin
        take = cond_main;
        pop  = cond_main;
      end
      ACT_RETN: begin
        take  = 1'b1;
        pop   = 1'b1;
        iload = 1'b1;
      end
      ACT_RST: begin
        take = 1'b1;
        push = 1'b1;
        npc  = 16'(req.y_field) << RstShift;
      end
      default: begin
      end
    endcase
  end

  // Assemble the result; a pop overrides the PC with the stack word
  always_comb begin
    res.next_pc      = pop ? req.pop_word : npc;
    res.next_sp      = pop ? sp_inc : (push ? sp_dec : req.sp_in);
    res.next_b       = (act == ACT_DJNZ) ? b_dec : req.b_in;
    res.taken        = take;
    res.push_enable  = push;
    res.push_address = push ? sp_dec : 16'd0;
    res.push_word    = push ? req.pc_in : 16'd0;
    res.pop_used     = pop;
    res.iff1_load    = iload;
    res.iff1_value   = iload & req.iff2_in;
  end

endmodule

`default_nettype wire

// ===== src/branch_call_return_resolver_unit.sv =====
// Branch/call/return resolver: input register, decode logic, result register.
// A request is captured in the input register, resolved, and its result captured in the result register.
// Throughput: one request per cycle; stalls ripple back through both stages.
// Reset clears both stage valid bits; payload registers are not reset.
// Depends on bcrr_pkg and bcrr_resolve.
`default_nettype none

module branch_call_return_resolver_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  action,
  input  wire logic [2:0]  y_field,
  input  wire logic [7:0]  flags,
  input  wire logic [15:0] pc_in,
  input  wire logic [15:0] sp_in,
  input  wire logic [15:0] hl_in,
  input  wire logic [7:0]  b_in,
  input  wire logic [15:0] imm_word,
  input  wire logic [7:0]  disp_byte,
  input  wire logic [15:0] pop_word,
  input  wire logic        iff2_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      next_pc,
  output logic [15:0]      next_sp,
  output logic [7:0]       next_b,
  output logic             taken,
  output logic             push_enable,
  output logic [15:0]      push_address,
  output logic [15:0]      push_word,
  output logic             pop_used,
  output logic             iff1_load,
  output logic             iff1_value
);
  import bcrr_pkg::*;

  request_t req_reg;
  logic     req_valid;
  result_t  res_comb;
  result_t  res_reg;
  logic     res_load;
  logic     req_load;

  // Advance each stage when its downstream slot is free
  assign res_load = !out_valid || !out_stall;
  assign req_load = !req_valid || res_load;
  assign in_stall = !req_load;

  // Input stage: capture request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_load) begin
      req_valid <= in_valid;
    end
    if (req_load && in_valid) begin
      req_reg <= '{action: action, y_field: y_field, flags: flags, pc_in: pc_in,
                   sp_in: sp_in, hl_in: hl_in, b_in: b_in, imm_word: imm_word,
                   disp_byte: disp_byte, pop_word: pop_word, iff2_in: iff2_in};
    end
  end

  bcrr_resolve u_resolve (
    .req (req_reg),
    .res (res_comb)
  );

  // Result stage: hold until taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= req_valid;
    end
    if (res_load && req_valid) begin
      res_reg <= res_comb;
    end
  end

  assign next_pc      = res_reg.next_pc;
  assign next_sp      = res_reg.next_sp;
  assign next_b       = res_reg.next_b;
  assign taken        = res_reg.taken;
  assign push_enable  = res_reg.push_enable;
  assign push_address = res_reg.push_address;
  assign push_word    = res_reg.push_word;
  assign pop_used     = res_reg.pop_used;
  assign iff1_load    = res_reg.iff1_load;
  assign iff1_value   = res_reg.iff1_value;

endmodule

`default_nettype wire

// ===== sim/branch_call_return_resolver_unit_tb.sv =====
// Self-checking testbench for branch_call_return_resolver_unit.
// Drives branch/call/return requests, predicts each resolution and checks every result.
// Depends on bcrr_pkg and the resolver RTL only.
`timescale 1ns / 1ps

module branch_call_return_resolver_unit_tb;
  import bcrr_pkg::*;

  // Action codes with no operation behind them
  localparam logic [3:0] ActUnusedLo = 4'd13;
  localparam logic [3:0] ActUnusedHi = 4'd15;
  localparam int         IdleLimit   = 2000;
  localparam int         MaxReports  = 200;
  localparam int         RandomCount = 1000;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  request_t    req_drv;
  logic [15:0] next_pc;
  logic [15:0] next_sp;
  logic [7:0]  next_b;
  logic        taken;
  logic        push_enable;
  logic [15:0] push_address;
  logic [15:0] push_word;
  logic        pop_used;
  logic        iff1_load;
  logic        iff1_value;
  result_t     res_seen;

  result_t     pending_results[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left;
  stall_mode_t stall_mode = StallNone;
  int          stall_mode_left = 0;
  int          stall_tick = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  branch_call_return_resolver_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (req_drv.action),
    .y_field      (req_drv.y_field),
    .flags        (req_drv.flags),
    .pc_in        (req_drv.pc_in),
    .sp_in        (req_drv.sp_in),
    .hl_in        (req_drv.hl_in),
    .b_in         (req_drv.b_in),
    .imm_word     (req_drv.imm_word),
    .disp_byte    (req_drv.disp_byte),
    .pop_word     (req_drv.pop_word),
    .iff2_in      (req_drv.iff2_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .next_pc      (next_pc),
    .next_sp      (next_sp),
    .next_b       (next_b),
    .taken        (taken),
    .push_enable  (push_enable),
    .push_address (push_address),
    .push_word    (push_word),
    .pop_used     (pop_used),
    .iff1_load    (iff1_load),
    .iff1_value   (iff1_value)
  );

  assign res_seen = {next_pc, next_sp, next_b, taken, push_enable, push_address,
                     push_word, pop_used, iff1_load, iff1_value};

  // Condition test: pick Z, C, PV or S by the upper index bits, compare to the low bit
  function automatic logic cc_met(input logic [2:0] cond, input logic [7:0] f);
    logic [3:0] flag_sel;
    flag_sel = {f[FlagS], f[FlagPv], f[FlagC], f[FlagZ]};
    return ~(flag_sel[cond[2:1]] ^ cond[0]);
  endfunction

  // Resolve one control-flow request into next PC/SP/B and stack requests
  function automatic result_t resolve_branch(input request_t r);
    result_t     o;
    logic [15:0] rel_pc;
    rel_pc = r.pc_in + {{8{r.disp_byte[7]}}, r.disp_byte};
    o = '0;
    o.next_pc = r.pc_in;
    o.next_sp = r.sp_in;
    o.next_b  = r.b_in;
    case (r.action)
      ACT_JP: begin
        o.taken = 1'b1;
        o.next_pc = r.imm_word;
      end
      ACT_JP_CC: if (cc_met(r.y_field, r.flags)) begin
        o.taken = 1'b1;
        o.next_pc = r.imm_word;
      end
      ACT_JR: begin
        o.taken = 1'b1;
        o.next_pc = rel_pc;
      end
      ACT_JR_CC: if (cc_met(r.y_field - 3'd4, r.flags)) begin
        o.taken = 1'b1;
        o.next_pc = rel_pc;
      end
      ACT_DJNZ: begin
        o.next_b = r.b_in - 8'd1;
        if (o.next_b != 8'd0) begin
          o.taken = 1'b1;
          o.next_pc = rel_pc;
        end
      end
      ACT_JP_HL: begin
        o.taken = 1'b1;
        o.next_pc = r.hl_in;
      end
      ACT_CALL: begin
        o.taken = 1'b1;
        o.push_enable = 1'b1;
        o.next_pc = r.imm_word;
      end
      ACT_CALL_CC: if (cc_met(r.y_field, r.flags)) begin
        o.taken = 1'b1;
        o.push_enable = 1'b1;
        o.next_pc = r.imm_word;
      end
      ACT_RET, ACT_RETI: begin
        o.taken = 1'b1;
        o.pop_used = 1'b1;
      end
      ACT_RET_CC: if (cc_met(r.y_field, r.flags)) begin
        o.taken = 1'b1;
        o.pop_used = 1'b1;
      end
      ACT_RETN: begin
        o.taken = 1'b1;
        o.pop_used = 1'b1;
        o.iff1_load = 1'b1;
        o.iff1_value = r.iff2_in;
      end
      ACT_RST: begin
        o.taken = 1'b1;
        o.push_enable = 1'b1;
        o.next_pc = {10'd0, r.y_field, 3'd0};
      end
      default: ;
    endcase
    if (o.push_enable) begin
      o.next_sp = r.sp_in - 16'd2;
      o.push_address = r.sp_in - 16'd2;
      o.push_word = r.pc_in;
    end
    if (o.pop_used) begin
      o.next_pc = r.pop_word;
      o.next_sp = r.sp_in + 16'd2;
    end
    return o;
  endfunction

  // Random request, biased toward wrap points of PC, SP, B and the displacement
  function automatic request_t random_request();
    request_t r;
    r.action    = ($urandom_range(0, 24) == 0) ? 4'($urandom_range(ActUnusedLo, ActUnusedHi))
                                               : 4'($urandom_range(ACT_JP, ACT_RST));
    r.y_field   = 3'($urandom);
    r.flags     = 8'($urandom);
    r.pc_in     = 16'($urandom);
    r.sp_in     = 16'($urandom);
    r.hl_in     = 16'($urandom);
    r.b_in      = 8'($urandom);
    r.imm_word  = 16'($urandom);
    r.disp_byte = 8'($urandom);
    r.pop_word  = 16'($urandom);
    r.iff2_in   = 1'($urandom);
    if ($urandom_range(0, 7) == 0)
      r.sp_in = $urandom_range(0, 1) ? 16'(16'hFFFF - $urandom_range(0, 1))
                                     : 16'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) r.pc_in = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(0, 5) == 0) r.b_in = 8'($urandom_range(0, 2));
    if ($urandom_range(0, 7) == 0) r.disp_byte = $urandom_range(0, 1) ? 8'h7F : 8'h80;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, fname, want, got);
    end
  endtask

  // Idle the sender between bursts of random length
  task automatic pace_sender();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  // Present one request at the falling edge and hold it until accepted
  task automatic send_request(input request_t r);
    req_drv  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    pace_sender();
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_jumps();
    request_t r;
    r = random_request(); r.action = ACT_JP; r.imm_word = 16'hFFFF; send_request(r);
    r = random_request(); r.action = ACT_JR; r.pc_in = 16'hFFFF; r.disp_byte = 8'h7F;
    send_request(r);
    r = random_request(); r.action = ACT_JR; r.pc_in = 16'h0000; r.disp_byte = 8'h80;
    send_request(r);
    r = random_request(); r.action = ACT_JP_HL; r.hl_in = 16'h0000; send_request(r);
  endtask

  task automatic test_calls_returns();
    request_t r;
    r = random_request(); r.action = ACT_CALL; r.sp_in = 16'h0000; r.pc_in = 16'hFFFF;
    r.imm_word = 16'h0000; send_request(r);
    r = random_request(); r.action = ACT_CALL; r.sp_in = 16'h0001; send_request(r);
    r = random_request(); r.action = ACT_RET; r.sp_in = 16'hFFFF; r.pop_word = 16'hFFFF;
    send_request(r);
    r = random_request(); r.action = ACT_RETI; r.sp_in = 16'hFFFE; r.pop_word = 16'h0000;
    send_request(r);
    r = random_request(); r.action = ACT_RETN; r.iff2_in = 1'b1; send_request(r);
    r = random_request(); r.action = ACT_RETN; r.iff2_in = 1'b0; send_request(r);
    r = random_request(); r.action = ACT_RST; r.y_field = 3'd7; send_request(r);
    r = random_request(); r.action = ACT_RST; r.y_field = 3'd0; r.sp_in = 16'h0001;
    send_request(r);
  endtask

  // Conditional forms, including the shifted JR condition index
  task automatic test_conditions();
    request_t r;
    r = random_request(); r.action = ACT_JP_CC; r.y_field = 3'd0; r.flags = 8'h00;
    send_request(r);
    r = random_request(); r.action = ACT_CALL_CC; r.y_field = 3'd3; r.flags = 8'h00;
    send_request(r);
    r = random_request(); r.action = ACT_RET_CC; r.y_field = 3'd5; r.flags = 8'h04;
    send_request(r);
    r = random_request(); r.action = ACT_JR_CC; r.y_field = 3'd4; r.flags = 8'h40;
    send_request(r);
    r = random_request(); r.action = ACT_JR_CC; r.y_field = 3'd3; r.flags = 8'h80;
    send_request(r);
  endtask

  // Loop counter at zero, one and two
  task automatic test_djnz();
    request_t r;
    r = random_request(); r.action = ACT_DJNZ; r.b_in = 8'd1; send_request(r);
    r = random_request(); r.action = ACT_DJNZ; r.b_in = 8'd0; r.disp_byte = 8'h80;
    send_request(r);
    r = random_request(); r.action = ACT_DJNZ; r.b_in = 8'd2; r.disp_byte = 8'h00;
    send_request(r);
  endtask

  // Unused action codes pass PC, SP and B through
  task automatic test_unused_actions();
    request_t r;
    r = '1; r.action = ActUnusedLo; send_request(r);
    r = '1; r.action = ActUnusedHi; send_request(r);
  endtask

  task automatic test_random_flow(input int count);
    for (int i = 0; i < count; i++) send_request(random_request());
  endtask

  task automatic test_drain_pause();
    drain_results();
  endtask

  // Receiver stall: pick a new stall mode whenever the current one runs out
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(20, 150);
    end else begin
      stall_mode_left--;
    end
    stall_tick++;
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= (stall_tick % 5) < 2;
    endcase
  end

  // Check results, record accepted requests, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, actual next_pc 0x%h", $time, next_pc);
        end else begin
          result_t want;
          want = pending_results.pop_front();
          check_field("next_pc", want.next_pc, res_seen.next_pc);
          check_field("next_sp", want.next_sp, res_seen.next_sp);
          check_field("next_b", 16'(want.next_b), 16'(res_seen.next_b));
          check_field("taken", 16'(want.taken), 16'(res_seen.taken));
          check_field("push_enable", 16'(want.push_enable), 16'(res_seen.push_enable));
          check_field("push_address", want.push_address, res_seen.push_address);
          check_field("push_word", want.push_word, res_seen.push_word);
          check_field("pop_used", 16'(want.pop_used), 16'(res_seen.pop_used));
          check_field("iff1_load", 16'(want.iff1_load), 16'(res_seen.iff1_load));
          check_field("iff1_value", 16'(want.iff1_value), 16'(res_seen.iff1_value));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        pending_results.push_back(resolve_branch(req_drv));
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("branch_call_return_resolver_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_drv = '0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_jumps();
    test_calls_returns();
    test_conditions();
    test_djnz();
    test_unused_actions();
    test_random_flow(RandomCount);
    test_drain_pause();
    test_random_flow(RandomCount);

    // Let the pipeline empty, then keep watching for stray results
    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("branch_call_return_resolver_unit_tb OK");
    end else begin
      $display("branch_call_return_resolver_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
